// ===== design/mrts_pkg.sv =====
// Shared types and constants for the multi-rate tick scheduler.
package mrts_pkg;

  localparam int OP_W     = 2;
  localparam int NOW_W    = 48;
  localparam int RIDX_W   = 3;
  localparam int PER_W    = 32;
  localparam int MASK_W   = 8;
  localparam int STATUS_W = 2;
  localparam int ACT_W    = 4;

  typedef enum logic [OP_W-1:0] {
    OP_ADVANCE  = 2'd0,
    OP_SET_RATE = 2'd1,
    OP_START    = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK          = 2'd0,
    STAT_BAD_INDEX   = 2'd1,
    STAT_ZERO_PERIOD = 2'd2,
    STAT_MISMATCH    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_DIV,
    S_ALIGN,
    S_SETW,
    S_DONE
  } state_t;

endpackage

// ===== design/multi_rate_tick_scheduler.sv =====
// Multi-rate tick scheduler: rate table in two memories walked by a sequencer.
//
//  channel | handshake                | payload
//  --------+--------------------------+-------------------------------------------
//  in      | start && !busy           | operation, now_tic, rate_index, period_tics
//  out     | out_strobe (one cycle)   | next_due_tic, fired_mask, status
//  cfg     | cfg_valid && cfg_ready   | cfg_data (active_rates)
//
// Advance and start walk n entries from accept to result, n being the active count:
// one memory read per entry, issued back to back through the shared read address.
// Set rate adds the realignment: a bit-serial remainder over the TIC_BITS bits of now,
// then the align and table-write states, then the same walk for the minimum. A set rate
// whose schedule has caught up with now skips the remainder. Errors go straight to the result.
// Reset is synchronous and clears the entry valid bits, so all entries read as zero
// at once. The receiver cannot stall; each result shows for exactly one cycle.
module multi_rate_tick_scheduler #(
  parameter int MAX_RATES = 8,
  parameter int TIC_BITS  = 48
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [mrts_pkg::OP_W-1:0]     in_operation,
  input  logic [mrts_pkg::NOW_W-1:0]    in_now_tic,
  input  logic [mrts_pkg::RIDX_W-1:0]   in_rate_index,
  input  logic [mrts_pkg::PER_W-1:0]    in_period_tics,
  output logic                          out_strobe,
  output logic [mrts_pkg::NOW_W-1:0]    out_next_due_tic,
  output logic [mrts_pkg::MASK_W-1:0]   out_fired_mask,
  output logic [mrts_pkg::STATUS_W-1:0] out_status,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mrts_pkg::ACT_W-1:0]    cfg_data
);
  import mrts_pkg::*;

  localparam int IDX_W = (MAX_RATES > 1) ? $clog2(MAX_RATES) : 1;
  localparam int CNT_W = $clog2(MAX_RATES + 1);
  localparam int SUM_W = ((TIC_BITS > PER_W) ? TIC_BITS : PER_W) + 1;
  localparam int DIV_W = $clog2(TIC_BITS + 1);
  localparam logic [TIC_BITS-1:0] TIC_MAX = {TIC_BITS{1'b1}};

  function automatic logic [TIC_BITS-1:0] sat_add(input logic [TIC_BITS-1:0] a,
                                                  input logic [PER_W-1:0] b);
    logic [SUM_W-1:0] s;
    s = SUM_W'(a) + SUM_W'(b);
    if (s > SUM_W'(TIC_MAX)) return TIC_MAX;
    return s[TIC_BITS-1:0];
  endfunction

  // Control and working registers.
  state_t                state_r, state_nxt;
  op_t                   op_r, op_nxt;
  logic [TIC_BITS-1:0]   now_r, now_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt;
  logic [PER_W-1:0]      per_r, per_nxt;
  logic [CNT_W-1:0]      n_r, n_nxt;
  logic [TIC_BITS-1:0]   sched_r, sched_nxt;
  logic [TIC_BITS-1:0]   min_r, min_nxt;
  logic [MASK_W-1:0]     fired_r, fired_nxt;
  status_t               status_r, status_nxt;
  logic [CNT_W-1:0]      rd_cnt_r, rd_cnt_nxt;
  logic                  pipe_vld_r, pipe_vld_nxt;
  logic [IDX_W-1:0]      pipe_idx_r, pipe_idx_nxt;
  logic [PER_W-1:0]      rem_r, rem_nxt;
  logic [TIC_BITS-1:0]   div_sh_r, div_sh_nxt;
  logic [DIV_W-1:0]      div_cnt_r, div_cnt_nxt;
  logic [TIC_BITS-1:0]   next_r, next_nxt;
  logic                  align_r, align_nxt;
  logic [ACT_W-1:0]      active_r, active_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [NOW_W-1:0]      out_due_r, out_due_nxt;
  logic [MASK_W-1:0]     out_fired_r, out_fired_nxt;
  logic [STATUS_W-1:0]   out_status_r, out_status_nxt;

  // Rate table storage; an entry never written reads as zero through its valid bit.
  logic [PER_W-1:0]      per_mem [MAX_RATES];
  logic [TIC_BITS-1:0]   due_mem [MAX_RATES];
  logic [MAX_RATES-1:0]  per_vld_r, due_vld_r;
  logic [PER_W-1:0]      per_rd_r;
  logic [TIC_BITS-1:0]   due_rd_r;
  logic                  per_rv_r, due_rv_r;

  logic [IDX_W-1:0]      ra, wa;
  logic                  per_we, due_we;
  logic [TIC_BITS-1:0]   due_wd;
  logic [PER_W-1:0]      per_q;
  logic [TIC_BITS-1:0]   due_q;
  logic [TIC_BITS-1:0]   ent_val;
  logic [TIC_BITS-1:0]   now_in;
  logic [CNT_W-1:0]      n_in;
  logic [PER_W:0]        trial;
  logic                  accept;

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = (state_r == S_IDLE);

  assign out_strobe       = out_valid_r;
  assign out_next_due_tic = out_due_r;
  assign out_fired_mask   = out_fired_r;
  assign out_status       = out_status_r;

  assign now_in = TIC_BITS'(in_now_tic);
  assign per_q  = per_rv_r ? per_rd_r : '0;
  assign due_q  = due_rv_r ? due_rd_r : '0;
  assign ra     = rd_cnt_r[IDX_W-1:0];
  assign trial  = {rem_r, div_sh_r[TIC_BITS-1]};

  always_comb begin
    if (active_r == '0) begin
      n_in = CNT_W'(1);
    end else if (32'(active_r) > MAX_RATES) begin
      n_in = CNT_W'(MAX_RATES);
    end else begin
      n_in = CNT_W'(active_r);
    end
  end

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    now_nxt        = now_r;
    idx_nxt        = idx_r;
    per_nxt        = per_r;
    n_nxt          = n_r;
    sched_nxt      = sched_r;
    min_nxt        = min_r;
    fired_nxt      = fired_r;
    status_nxt     = status_r;
    rd_cnt_nxt     = rd_cnt_r;
    pipe_vld_nxt   = 1'b0;
    pipe_idx_nxt   = pipe_idx_r;
    rem_nxt        = rem_r;
    div_sh_nxt     = div_sh_r;
    div_cnt_nxt    = div_cnt_r;
    next_nxt       = next_r;
    align_nxt      = align_r;
    active_nxt     = active_r;
    out_valid_nxt  = 1'b0;
    out_due_nxt    = out_due_r;
    out_fired_nxt  = out_fired_r;
    out_status_nxt = out_status_r;
    per_we         = 1'b0;
    due_we         = 1'b0;
    wa             = pipe_idx_r;
    due_wd         = '0;
    ent_val        = due_q;

    if (cfg_valid && cfg_ready) begin
      active_nxt = cfg_data;
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt     = op_t'(in_operation);
          now_nxt    = now_in;
          idx_nxt    = IDX_W'(in_rate_index);
          per_nxt    = in_period_tics;
          n_nxt      = n_in;
          fired_nxt  = '0;
          status_nxt = STAT_OK;
          min_nxt    = TIC_MAX;
          rd_cnt_nxt = '0;
          unique case (op_t'(in_operation))
            OP_ADVANCE: begin
              if (now_in != sched_r) begin
                status_nxt = STAT_MISMATCH;
                state_nxt  = S_DONE;
              end else begin
                state_nxt = S_WALK;
              end
            end
            OP_SET_RATE: begin
              if (32'(in_rate_index) >= 32'(n_in)) begin
                status_nxt = STAT_BAD_INDEX;
                state_nxt  = S_DONE;
              end else if (in_period_tics == '0) begin
                status_nxt = STAT_ZERO_PERIOD;
                state_nxt  = S_DONE;
              end else if (sched_r > now_in) begin
                rem_nxt     = '0;
                div_sh_nxt  = now_in;
                div_cnt_nxt = '0;
                align_nxt   = 1'b1;
                state_nxt   = S_DIV;
              end else begin
                // The schedule has caught up with now: the entry is due at once.
                next_nxt  = now_in;
                align_nxt = 1'b0;
                state_nxt = S_SETW;
              end
            end
            OP_START: begin
              state_nxt = S_WALK;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end

      S_WALK: begin
        // Reads are issued one per cycle; the entry read last cycle is handled now.
        if (rd_cnt_r < n_r) begin
          pipe_vld_nxt = 1'b1;
          pipe_idx_nxt = rd_cnt_r[IDX_W-1:0];
          rd_cnt_nxt   = rd_cnt_r + CNT_W'(1);
        end
        if (pipe_vld_r) begin
          unique case (op_r)
            OP_ADVANCE: begin
              if (due_q == sched_r) begin
                ent_val   = sat_add(due_q, per_q);
                due_we    = 1'b1;
                fired_nxt = fired_r | (MASK_W'(1) << pipe_idx_r);
              end
            end
            OP_START: begin
              ent_val = sat_add(now_r, per_q);
              due_we  = 1'b1;
            end
            default: begin
              ent_val = due_q;
            end
          endcase
          due_wd  = ent_val;
          min_nxt = (ent_val < min_r) ? ent_val : min_r;
          if (CNT_W'(pipe_idx_r) == n_r - CNT_W'(1)) begin
            sched_nxt = min_nxt;
            state_nxt = S_DONE;
          end
        end
      end

      S_DIV: begin
        // Restoring remainder, one bit of now per cycle, most significant first.
        if (trial >= {1'b0, per_r}) begin
          rem_nxt = PER_W'(trial - {1'b0, per_r});
        end else begin
          rem_nxt = trial[PER_W-1:0];
        end
        div_sh_nxt  = {div_sh_r[TIC_BITS-2:0], 1'b0};
        div_cnt_nxt = div_cnt_r + DIV_W'(1);
        if (div_cnt_r == DIV_W'(TIC_BITS - 1)) begin
          state_nxt = S_ALIGN;
        end
      end

      S_ALIGN: begin
        next_nxt  = now_r - TIC_BITS'(rem_r);
        state_nxt = S_SETW;
      end

      S_SETW: begin
        wa         = idx_r;
        per_we     = 1'b1;
        due_we     = 1'b1;
        due_wd     = align_r ? sat_add(next_r, per_r) : next_r;
        rd_cnt_nxt = '0;
        min_nxt    = TIC_MAX;
        state_nxt  = S_WALK;
      end

      S_DONE: begin
        out_valid_nxt  = 1'b1;
        out_due_nxt    = NOW_W'(sched_r);
        out_fired_nxt  = (status_r == STAT_OK) ? fired_r : '0;
        out_status_nxt = status_r;
        state_nxt      = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sched_r     <= '0;
      active_r    <= ACT_W'(1);
      out_valid_r <= 1'b0;
      pipe_vld_r  <= 1'b0;
      per_vld_r   <= '0;
      due_vld_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      sched_r     <= sched_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
      pipe_vld_r  <= pipe_vld_nxt;
      if (per_we) per_vld_r[wa] <= 1'b1;
      if (due_we) due_vld_r[wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    now_r        <= now_nxt;
    idx_r        <= idx_nxt;
    per_r        <= per_nxt;
    n_r          <= n_nxt;
    min_r        <= min_nxt;
    fired_r      <= fired_nxt;
    status_r     <= status_nxt;
    rd_cnt_r     <= rd_cnt_nxt;
    pipe_idx_r   <= pipe_idx_nxt;
    rem_r        <= rem_nxt;
    div_sh_r     <= div_sh_nxt;
    div_cnt_r    <= div_cnt_nxt;
    next_r       <= next_nxt;
    align_r      <= align_nxt;
    out_due_r    <= out_due_nxt;
    out_fired_r  <= out_fired_nxt;
    out_status_r <= out_status_nxt;
    per_rv_r     <= per_vld_r[ra];
    due_rv_r     <= due_vld_r[ra];
  end

  always_ff @(posedge clk) begin
    if (per_we) per_mem[wa] <= per_r;
    per_rd_r <= per_mem[ra];
  end

  always_ff @(posedge clk) begin
    if (due_we) due_mem[wa] <= due_wd;
    due_rd_r <= due_mem[ra];
  end

endmodule

// ===== design/mrts_checker.sv =====
// Port-level checks for the multi-rate tick scheduler, bound to its top level.
module mrts_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          start,
  input logic                          busy,
  input logic                          out_strobe,
  input logic [mrts_pkg::MASK_W-1:0]   out_fired_mask,
  input logic [mrts_pkg::STATUS_W-1:0] out_status
);
  import mrts_pkg::*;

  // The block is always busy in the cycle after it accepts an item.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("block not busy after an accepted item");

  // A result beat appears exactly as the block returns to idle.
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy)
    else $error("result beat while still busy");

  // One result per item: beats never come back to back.
  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("two result beats in a row");

  // Any error status leaves the fired mask empty.
  a_error_no_fire: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && (out_status != STAT_OK)) |-> (out_fired_mask == '0))
    else $error("entries reported fired on an error");

endmodule

bind multi_rate_tick_scheduler mrts_checker u_mrts_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_strobe     (out_strobe),
  .out_fired_mask (out_fired_mask),
  .out_status     (out_status)
);
